@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file ogsi_checker.sv.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

`endif

@@ hw/rtl/ogsi_pkg.sv @@
`timescale 1ns / 1ps
package ogsi_pkg;

  localparam int OGSI_MAX_WIDTH  = 128;
  localparam int OGSI_MAX_HEIGHT = 128;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  localparam logic [2:0] REG_GRID_WIDTH    = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_OCCUPIED_CODE = 3'd2;
  localparam logic [2:0] REG_BLOCKED_CODE  = 3'd3;
  localparam logic [2:0] REG_FLAT_CODE     = 3'd4;

  localparam logic [1:0] OUT_ZERO = 2'd0;
  localparam logic [1:0] OUT_READ = 2'd1;
  localparam logic [1:0] OUT_DONE = 2'd2;

  // Neighbour offsets, visited in this order.
  localparam logic signed [1:0] NB_DX [8] = '{-2'sd1, 2'sd0, 2'sd0, 2'sd1,
                                              2'sd1, -2'sd1, 2'sd1, -2'sd1};
  localparam logic signed [1:0] NB_DY [8] = '{2'sd0, 2'sd1, -2'sd1, 2'sd0,
                                              2'sd1, -2'sd1, -2'sd1, 2'sd1};

  // ceil(2^16 / 9): exact floor division for magnitudes up to 1152.
  localparam logic [12:0] RECIP_NINE = 13'd7282;

  typedef struct packed {
    logic       host_wr;
    logic       host_rd;
    logic       out_load;
    logic [1:0] out_sel;
    logic       cnt_clr;
    logic       cnt_adv;
    logic       copy_rd;
    logic       ctr_rd;
    logic       nb_clr;
    logic       nb_rd;
    logic       nb_acc;
    logic       nb_adv;
    logic       mul;
    logic       res_wr;
    logic       fill_ld;
    logic       pass2;
  } ogsi_cmd_t;

  typedef struct packed {
    logic zero_area;
    logic last_cell;
    logic ctr_hit;
    logic nb_out;
    logic nb_last;
    logic nb_bad;
    logic out_free;
  } ogsi_stat_t;

endpackage

@@ hw/rtl/ogsi_ctrl.sv @@
`timescale 1ns / 1ps
module ogsi_ctrl
  import ogsi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_stall,
  input  ogsi_stat_t stat,
  output ogsi_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDOUT = 4'd1;
  localparam logic [3:0] S_COPY  = 4'd2;
  localparam logic [3:0] S_CPFL  = 4'd3;
  localparam logic [3:0] S_CTR   = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_NRD   = 4'd6;
  localparam logic [3:0] S_NACC  = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_WR    = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       pass2_r, pass2_nxt;
  logic       go_next;
  logic       accept;

  assign in_stall = (state_r != S_IDLE) || !stat.out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    pass2_nxt = pass2_r;
    go_next   = 1'b0;
    cmd       = '0;
    cmd.pass2 = pass2_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_WRITE: begin
              cmd.host_wr  = 1'b1;
              cmd.out_load = 1'b1;
              cmd.out_sel  = OUT_ZERO;
            end
            FUNC_READ: begin
              cmd.host_rd = 1'b1;
              state_nxt   = S_RDOUT;
            end
            FUNC_RUN: begin
              if (stat.zero_area) begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = OUT_DONE;
              end else begin
                cmd.cnt_clr = 1'b1;
                pass2_nxt   = 1'b0;
                state_nxt   = S_COPY;
              end
            end
            default: begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = OUT_ZERO;
            end
          endcase
        end
      end
      S_RDOUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_READ;
          state_nxt    = S_IDLE;
        end
      end
      S_COPY: begin
        cmd.copy_rd = 1'b1;
        if (stat.last_cell) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_CPFL;
        end else begin
          cmd.cnt_adv = 1'b1;
        end
      end
      S_CPFL: begin
        state_nxt = S_CTR;
      end
      S_CTR: begin
        cmd.ctr_rd = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        if (stat.ctr_hit) begin
          cmd.nb_clr  = 1'b1;
          cmd.fill_ld = 1'b1;
          state_nxt   = S_NRD;
        end else begin
          go_next = 1'b1;
        end
      end
      S_NRD: begin
        if (stat.nb_out) begin
          if (!pass2_r || stat.nb_last) begin
            go_next = 1'b1;
          end else begin
            cmd.nb_adv = 1'b1;
          end
        end else begin
          cmd.nb_rd = 1'b1;
          state_nxt = S_NACC;
        end
      end
      S_NACC: begin
        cmd.nb_acc = 1'b1;
        cmd.nb_adv = 1'b1;
        if (!pass2_r && stat.nb_bad) begin
          go_next = 1'b1;
        end else if (stat.nb_last) begin
          if (pass2_r) begin
            go_next = 1'b1;
          end else begin
            state_nxt = S_MUL;
          end
        end else begin
          state_nxt = S_NRD;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.res_wr = 1'b1;
        go_next    = 1'b1;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_DONE;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (go_next) begin
      if (stat.last_cell) begin
        if (!pass2_r) begin
          cmd.cnt_clr = 1'b1;
          pass2_nxt   = 1'b1;
          state_nxt   = S_CTR;
        end else begin
          state_nxt = S_DONE;
        end
      end else begin
        cmd.cnt_adv = 1'b1;
        state_nxt   = S_CTR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass2_r <= pass2_nxt;
    end
  end

endmodule

@@ hw/rtl/ogsi_dp.sv @@
`timescale 1ns / 1ps
module ogsi_dp
  import ogsi_pkg::*;
#(
  parameter int MAX_WIDTH  = OGSI_MAX_WIDTH,
  parameter int MAX_HEIGHT = OGSI_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ogsi_cmd_t         cmd,
  output ogsi_stat_t        stat,
  input  logic [6:0]        in_cell_x,
  input  logic [6:0]        in_cell_y,
  input  logic signed [7:0] in_cell_value,
  input  logic [7:0]        grid_width,
  input  logic [7:0]        grid_height,
  input  logic signed [7:0] occupied_code,
  input  logic signed [7:0] blocked_code,
  input  logic signed [7:0] flat_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] out_read_value,
  output logic              out_done_res
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);

  logic [7:0] grid_mem [CELLS];
  logic [7:0] snap_mem [CELLS];

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic [2:0]    d_r;
  logic          last_x, last_y;
  logic [AW-1:0] host_addr, ctr_addr, nb_addr;
  logic          host_inside;
  logic signed [XW+1:0] nx;
  logic signed [YW+1:0] ny;

  logic          grid_we, grid_re, snap_re;
  logic [AW-1:0] grid_wa, grid_ra, snap_ra;
  logic [7:0]    grid_wd;
  logic [7:0]    grid_q_r, snap_q_r;
  logic          copy_pend_r;
  logic [AW-1:0] cpy_addr_r, nb_addr_r;
  logic          rd_inside_r;

  logic signed [7:0]  q;
  logic signed [11:0] sum_r;
  logic signed [11:0] total;
  logic [10:0]        mag;
  logic               neg_r;
  logic [23:0]        prod_r;
  logic [7:0]         quo;
  logic [7:0]         res;
  logic signed [7:0]  fill_r;

  logic              out_valid_r;
  logic signed [7:0] out_read_value_r;
  logic              out_done_res_r;

  assign w_eff = (32'(grid_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(grid_width);
  assign h_eff = (32'(grid_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(grid_height);

  assign last_x = (32'(x_r) + 1) == 32'(w_eff);
  assign last_y = (32'(y_r) + 1) == 32'(h_eff);

  assign host_inside = (32'(in_cell_x) < MAX_WIDTH) && (32'(in_cell_y) < MAX_HEIGHT);
  assign host_addr   = AW'(AW'(in_cell_y) * AW'(MAX_WIDTH)) + AW'(in_cell_x);
  assign ctr_addr    = AW'(AW'(y_r) * AW'(MAX_WIDTH)) + AW'(x_r);

  assign nx = $signed({2'b00, x_r}) + (XW+2)'(NB_DX[d_r]);
  assign ny = $signed({2'b00, y_r}) + (YW+2)'(NB_DY[d_r]);
  assign nb_addr = AW'(AW'(ny[YW-1:0]) * AW'(MAX_WIDTH)) + AW'(nx[XW-1:0]);

  assign q = cmd.pass2 ? $signed(grid_q_r) : $signed(snap_q_r);

  assign stat.zero_area = (w_eff == '0) || (h_eff == '0);
  assign stat.last_cell = last_x && last_y;
  assign stat.ctr_hit   = cmd.pass2 ? ((q == occupied_code) || (q == blocked_code))
                                    : (q == occupied_code);
  assign stat.nb_out    = (nx < 0) || (nx >= $signed((XW+2)'(w_eff))) ||
                          (ny < 0) || (ny >= $signed((YW+2)'(h_eff)));
  assign stat.nb_last   = (d_r == 3'd7);
  // An unknown neighbour always counts, even when the occupied code is -1.
  assign stat.nb_bad    = (q == occupied_code) && (q != -8'sd1);
  assign stat.out_free  = !out_valid_r || !out_stall;

  // Pass 1 result: (center + neighbour sum) / 9, center being the occupied code.
  assign total = sum_r + 12'(occupied_code);
  assign quo   = prod_r[23:16];
  assign res   = neg_r ? (8'd0 - quo) : quo;

  always_comb begin
    mag = total[11] ? 11'(-total) : 11'(total);
  end

  always_comb begin
    grid_we = 1'b0;
    grid_wa = ctr_addr;
    grid_wd = res;
    if (cmd.host_wr && host_inside) begin
      grid_we = 1'b1;
      grid_wa = host_addr;
      grid_wd = in_cell_value;
    end else if (cmd.res_wr) begin
      grid_we = 1'b1;
    end else if (cmd.nb_acc && cmd.pass2 && ($signed(grid_q_r) < flat_code)) begin
      grid_we = 1'b1;
      grid_wa = nb_addr_r;
      grid_wd = fill_r;
    end
  end

  always_comb begin
    grid_re = 1'b0;
    grid_ra = ctr_addr;
    if (cmd.host_rd) begin
      grid_re = 1'b1;
      grid_ra = host_addr;
    end else if (cmd.copy_rd || (cmd.ctr_rd && cmd.pass2)) begin
      grid_re = 1'b1;
    end else if (cmd.nb_rd && cmd.pass2) begin
      grid_re = 1'b1;
      grid_ra = nb_addr;
    end
  end

  assign snap_re = (cmd.ctr_rd || cmd.nb_rd) && !cmd.pass2;
  assign snap_ra = cmd.nb_rd ? nb_addr : ctr_addr;

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_wa] <= grid_wd;
    end
    if (grid_re) begin
      grid_q_r <= grid_mem[grid_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (copy_pend_r) begin
      snap_mem[cpy_addr_r] <= grid_q_r;
    end
    if (snap_re) begin
      snap_q_r <= snap_mem[snap_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      copy_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      copy_pend_r <= cmd.copy_rd;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      x_r <= '0;
      y_r <= '0;
    end else if (cmd.cnt_adv) begin
      if (last_y) begin
        y_r <= '0;
        x_r <= x_r + 1'b1;
      end else begin
        y_r <= y_r + 1'b1;
      end
    end
    if (cmd.copy_rd) begin
      cpy_addr_r <= ctr_addr;
    end
    if (cmd.nb_rd) begin
      nb_addr_r <= nb_addr;
    end
    if (cmd.host_rd) begin
      rd_inside_r <= host_inside;
    end
    if (cmd.nb_clr) begin
      d_r   <= '0;
      sum_r <= '0;
    end else begin
      if (cmd.nb_acc && !cmd.pass2 && (q != -8'sd1)) begin
        sum_r <= sum_r + 12'(q);
      end
      if (cmd.nb_adv) begin
        d_r <= d_r + 1'b1;
      end
    end
    if (cmd.fill_ld) begin
      fill_r <= (q == occupied_code) ? flat_code : (blocked_code - 8'sd1);
    end
    if (cmd.mul) begin
      neg_r  <= total[11];
      prod_r <= 24'(mag) * 24'(RECIP_NINE);
    end
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OUT_READ: begin
          out_read_value_r <= rd_inside_r ? $signed(grid_q_r) : 8'sd0;
          out_done_res_r   <= 1'b0;
        end
        OUT_DONE: begin
          out_read_value_r <= 8'sd0;
          out_done_res_r   <= 1'b1;
        end
        default: begin
          out_read_value_r <= 8'sd0;
          out_done_res_r   <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_done_res   = out_done_res_r;

endmodule

@@ hw/rtl/occupancy_grid_smooth_inflate_core.sv @@
`timescale 1ns / 1ps
// A write item (or the unused function code) has its beat out in the cycle after
// acceptance; a read item passes the read-out state, which waits for a free output;
// a run item copies the area, then scans each pass cell by cell, paced by the single
// read port of each store. One item at a time; writes sustain one per cycle while the
// output is not stalled. Reset (synchronous, active low) restores the configuration
// registers to their defaults and the controller to idle; cell stores are not cleared.
module occupancy_grid_smooth_inflate_core
  import ogsi_pkg::*;
#(
  parameter int MAX_WIDTH  = OGSI_MAX_WIDTH,
  parameter int MAX_HEIGHT = OGSI_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [6:0]        in_cell_x,
  input  logic [6:0]        in_cell_y,
  input  logic signed [7:0] in_cell_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] out_read_value,
  output logic              out_done_res,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // Configuration registers. Each sits at a 32-bit word; only the low byte is kept.
  logic [7:0]        grid_width_r;
  logic [7:0]        grid_height_r;
  logic signed [7:0] occupied_code_r;
  logic signed [7:0] blocked_code_r;
  logic signed [7:0] flat_code_r;
  logic              cfg_wr;

  ogsi_cmd_t  cmd;
  ogsi_stat_t stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r    <= 8'd128;
      grid_height_r   <= 8'd128;
      occupied_code_r <= 8'sd100;
      blocked_code_r  <= 8'sd99;
      flat_code_r     <= 8'sd50;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_GRID_WIDTH:    grid_width_r    <= cfg_pwdata[7:0];
        REG_GRID_HEIGHT:   grid_height_r   <= cfg_pwdata[7:0];
        REG_OCCUPIED_CODE: occupied_code_r <= cfg_pwdata[7:0];
        REG_BLOCKED_CODE:  blocked_code_r  <= cfg_pwdata[7:0];
        REG_FLAT_CODE:     flat_code_r     <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Read data: codes are returned as the byte that was written, zero extended.
  always_comb begin
    case (cfg_paddr[4:2])
      REG_GRID_WIDTH:    cfg_prdata = {24'd0, grid_width_r};
      REG_GRID_HEIGHT:   cfg_prdata = {24'd0, grid_height_r};
      REG_OCCUPIED_CODE: cfg_prdata = {24'd0, occupied_code_r};
      REG_BLOCKED_CODE:  cfg_prdata = {24'd0, blocked_code_r};
      REG_FLAT_CODE:     cfg_prdata = {24'd0, flat_code_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // The controller sequences the copy into the snapshot store, the smoothing pass and
  // the inflation pass; the datapath holds both cell stores, the scan counters and the
  // divide-by-nine multiplier.
  ogsi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ogsi_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_cell_value  (in_cell_value),
    .grid_width     (grid_width_r),
    .grid_height    (grid_height_r),
    .occupied_code  (occupied_code_r),
    .blocked_code   (blocked_code_r),
    .flat_code      (flat_code_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_done_res   (out_done_res)
  );

endmodule

@@ hw/rtl/ogsi_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ogsi_checker
  import ogsi_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        in_func,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [7:0] out_read_value,
  input logic              out_done_res
);

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_read_value) && $stable(out_done_res))
  `ASSERT_NEXT(a_write_beat, in_valid && !in_stall && (in_func == FUNC_WRITE), out_valid)
  `ASSERT_NEXT(a_read_busy, in_valid && !in_stall && (in_func == FUNC_READ), in_stall)
  `ASSERT_SAME(a_done_zero, out_valid && out_done_res, out_read_value == 8'sd0)

endmodule

bind occupancy_grid_smooth_inflate_core ogsi_checker u_ogsi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_func        (in_func),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_value (out_read_value),
  .out_done_res   (out_done_res)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import ogsi_pkg::*;

  localparam int GRID_CELLS  = OGSI_MAX_WIDTH * OGSI_MAX_HEIGHT;
  localparam int STALL_LIMIT = 200000;
  localparam int MAX_SHOWN   = 10;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_func;
  logic [6:0]        in_cell_x;
  logic [6:0]        in_cell_y;
  logic signed [7:0] in_cell_value;
  logic              out_valid;
  logic              out_stall;
  logic signed [7:0] out_read_value;
  logic              out_done_res;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [4:0]        cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  occupancy_grid_smooth_inflate_core dut (.*);

  // The clock runs at 50 MHz.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // One expected result beat: the cell value of a read and the run-done flag.
  typedef struct {
    logic signed [7:0] read_value;
    logic              done;
  } cell_result_t;

  // One row of the directed table. When has_exp is set the expected beat is
  // typed in by hand; otherwise the grid predictor supplies it.
  typedef struct {
    logic [1:0]        func;
    logic [6:0]        x;
    logic [6:0]        y;
    logic signed [7:0] value;
    bit                has_exp;
    logic signed [7:0] exp_value;
    logic              exp_done;
  } grid_row_t;

  cell_result_t      pending_results[$];
  int                mismatches;
  int                quiet_cycles;
  bit                calm;

  // Predictor state: the cell store, the copy that pass 1 reads, and the
  // register shadows. cells_written marks cells whose content is defined,
  // so that no read or run ever touches a cell the block never stored.
  logic signed [7:0] grid_model[GRID_CELLS];
  logic signed [7:0] snap_model[GRID_CELLS];
  bit                cells_written[GRID_CELLS];
  int                area_w;
  int                area_h;
  logic signed [7:0] occ_code;
  logic signed [7:0] blk_code;
  logic signed [7:0] flat_code_m;

  // Neighbour offsets in the order in which the block visits them; the order
  // matters in pass 2 because it updates the grid in place.
  int nbr_dx[8] = '{-1, 0, 0, 1, 1, -1, 1, -1};
  int nbr_dy[8] = '{0, 1, -1, 0, 1, -1, -1, 1};

  function automatic int clamped_w();
    return (area_w > OGSI_MAX_WIDTH) ? OGSI_MAX_WIDTH : area_w;
  endfunction

  function automatic int clamped_h();
    return (area_h > OGSI_MAX_HEIGHT) ? OGSI_MAX_HEIGHT : area_h;
  endfunction

  // Both passes of a run item over the area in use.
  function automatic void smooth_and_inflate();
    int w;
    int h;
    int sum;
    int cnt;
    int nx;
    int ny;
    int r;
    logic signed [7:0] v;
    logic signed [7:0] fill;
    w = clamped_w();
    h = clamped_h();
    snap_model = grid_model;
    // Pass 1: isolated obstacle cells are averaged with their neighbours.
    for (int x = 0; x < w; x++) begin
      for (int y = 0; y < h; y++) begin
        if (snap_model[y * OGSI_MAX_WIDTH + x] == occ_code) begin
          sum = 0;
          cnt = 0;
          for (int d = 0; d < 8; d++) begin
            nx = x + nbr_dx[d];
            ny = y + nbr_dy[d];
            if (nx >= 0 && nx < w && ny >= 0 && ny < h) begin
              v = snap_model[ny * OGSI_MAX_WIDTH + nx];
              if (v == -8'sd1) begin
                cnt++;
              end else if (v != occ_code) begin
                sum += v;
                cnt++;
              end
            end
          end
          if (cnt == 8) begin
            r = (int'(grid_model[y * OGSI_MAX_WIDTH + x]) + sum) / 9;
            grid_model[y * OGSI_MAX_WIDTH + x] = r[7:0];
          end
        end
      end
    end
    // Pass 2: raise low neighbours of obstacle and blocked cells, in place.
    for (int x = 0; x < w; x++) begin
      for (int y = 0; y < h; y++) begin
        v = grid_model[y * OGSI_MAX_WIDTH + x];
        if (v == occ_code || v == blk_code) begin
          // Occupied wins when the two codes are equal; blocked minus one wraps.
          fill = (v == occ_code) ? flat_code_m : blk_code - 8'sd1;
          for (int d = 0; d < 8; d++) begin
            nx = x + nbr_dx[d];
            ny = y + nbr_dy[d];
            if (nx >= 0 && nx < w && ny >= 0 && ny < h) begin
              if (grid_model[ny * OGSI_MAX_WIDTH + nx] < flat_code_m) begin
                grid_model[ny * OGSI_MAX_WIDTH + nx] = fill;
              end
            end
          end
        end
      end
    end
  endfunction

  // Works out the beat that an accepted item produces and updates the model.
  function automatic cell_result_t grid_outcome(logic [1:0] f, logic [6:0] x, logic [6:0] y,
                                               logic signed [7:0] v);
    cell_result_t res;
    int idx;
    idx = int'(y) * OGSI_MAX_WIDTH + int'(x);
    res.read_value = '0;
    res.done = 1'b0;
    case (f)
      FUNC_WRITE: begin
        grid_model[idx] = v;
        cells_written[idx] = 1'b1;
      end
      FUNC_RUN: begin
        smooth_and_inflate();
        res.done = 1'b1;
      end
      FUNC_READ: begin
        res.read_value = grid_model[idx];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Sends one item, with an occasional gap before it. The item's payload is
  // set at a falling edge and held until the rising edge that accepts it.
  task automatic send_cell_item(logic [1:0] f, logic [6:0] x, logic [6:0] y,
                                logic signed [7:0] v, bit has_exp = 1'b0,
                                logic signed [7:0] exp_value = '0, logic exp_done = 1'b0);
    cell_result_t res;
    if (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_cell_x     <= x;
    in_cell_y     <= y;
    in_cell_value <= v;
    do @(posedge clk); while (in_stall);
    res = grid_outcome(f, x, y, v);
    if (has_exp) begin
      res.read_value = exp_value;
      res.done = exp_done;
    end
    pending_results.insert(pending_results.size(), res);
    @(negedge clk);
  endtask

  // APB register write: setup cycle, then access cycle.
  task automatic write_reg(logic [2:0] index, logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= {24'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (index)
      REG_GRID_WIDTH:    area_w = int'(value);
      REG_GRID_HEIGHT:   area_h = int'(value);
      REG_OCCUPIED_CODE: occ_code = value;
      REG_BLOCKED_CODE:  blk_code = value;
      default:           flat_code_m = value;
    endcase
  endtask

  // Holds the sender back until every expected beat has come, so the block
  // is surely idle before its registers change.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_grid(int w, int h, logic [7:0] occ, logic [7:0] blk, logic [7:0] flat);
    drain_results();
    write_reg(REG_GRID_WIDTH, w[7:0]);
    write_reg(REG_GRID_HEIGHT, h[7:0]);
    write_reg(REG_OCCUPIED_CODE, occ);
    write_reg(REG_BLOCKED_CODE, blk);
    write_reg(REG_FLAT_CODE, flat);
  endtask

  // Cell content that hits the codes often, so both passes have work to do.
  function automatic logic signed [7:0] pick_cell_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return occ_code;
    if (roll < 40) return blk_code;
    if (roll < 50) return -8'sd1;
    if (roll < 58) return flat_code_m;
    if (roll < 62) return (roll[0]) ? 8'sh7f : 8'sh80;
    return 8'($urandom_range(255));
  endfunction

  // Writes every cell of the area in use, so that a run reads only defined cells.
  task automatic fill_area();
    for (int x = 0; x < clamped_w(); x++) begin
      for (int y = 0; y < clamped_h(); y++) begin
        send_cell_item(FUNC_WRITE, x[6:0], y[6:0], pick_cell_value());
      end
    end
  endtask

  task automatic random_items(int count);
    int roll;
    int x;
    int y;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        if ($urandom_range(99) < 70 && clamped_w() > 0 && clamped_h() > 0) begin
          x = $urandom_range(clamped_w() - 1);
          y = $urandom_range(clamped_h() - 1);
        end else begin
          x = $urandom_range(127);
          y = $urandom_range(127);
        end
        send_cell_item(FUNC_WRITE, x[6:0], y[6:0], pick_cell_value());
      end else if (roll < 89) begin
        x = $urandom_range(127);
        y = $urandom_range(127);
        if (!cells_written[y * OGSI_MAX_WIDTH + x]) begin
          // Fall back to a cell known to be defined.
          if (clamped_w() > 0 && clamped_h() > 0) begin
            x = $urandom_range(clamped_w() - 1);
            y = $urandom_range(clamped_h() - 1);
          end else begin
            x = 0;
            y = 0;
          end
        end
        send_cell_item(FUNC_READ, x[6:0], y[6:0], 8'($urandom_range(255)));
      end else if (roll < 96) begin
        send_cell_item(FUNC_RUN, 7'($urandom_range(127)), 7'($urandom_range(127)),
                       8'($urandom_range(255)));
      end else begin
        send_cell_item(FUNC_NONE, 7'($urandom_range(127)), 7'($urandom_range(127)),
                       8'($urandom_range(255)));
      end
    end
  endtask

  // Directed rows on a 3x3 area with default codes. The lone obstacle in the
  // middle has no obstacle neighbours, so pass 1 averages it:
  // (100 - 128 + 127 + 0) / 9 = 11, the unknown cell counting as zero.
  // No cell is then occupied or blocked, so pass 2 changes nothing.
  grid_row_t directed_rows[] = '{
    '{FUNC_WRITE, 7'd0, 7'd0, -8'sd128, 1'b1, 8'sd0, 1'b0},
    '{FUNC_WRITE, 7'd1, 7'd0, 8'sd127, 1'b1, 8'sd0, 1'b0},
    '{FUNC_WRITE, 7'd2, 7'd0, -8'sd1, 1'b1, 8'sd0, 1'b0},
    '{FUNC_WRITE, 7'd0, 7'd1, 8'sd0, 1'b1, 8'sd0, 1'b0},
    '{FUNC_WRITE, 7'd1, 7'd1, 8'sd100, 1'b1, 8'sd0, 1'b0},
    '{FUNC_WRITE, 7'd2, 7'd1, 8'sd0, 1'b1, 8'sd0, 1'b0},
    '{FUNC_WRITE, 7'd0, 7'd2, 8'sd0, 1'b1, 8'sd0, 1'b0},
    '{FUNC_WRITE, 7'd1, 7'd2, 8'sd0, 1'b1, 8'sd0, 1'b0},
    '{FUNC_WRITE, 7'd2, 7'd2, 8'sd0, 1'b1, 8'sd0, 1'b0},
    '{FUNC_WRITE, 7'd127, 7'd127, 8'sd127, 1'b1, 8'sd0, 1'b0},
    '{FUNC_READ, 7'd127, 7'd127, 8'sd0, 1'b1, 8'sd127, 1'b0},
    '{FUNC_READ, 7'd0, 7'd0, 8'sd0, 1'b1, -8'sd128, 1'b0},
    '{FUNC_NONE, 7'd127, 7'd127, -8'sd1, 1'b1, 8'sd0, 1'b0},
    '{FUNC_RUN, 7'd0, 7'd0, 8'sd0, 1'b1, 8'sd0, 1'b1},
    '{FUNC_READ, 7'd1, 7'd1, 8'sd0, 1'b1, 8'sd11, 1'b0},
    '{FUNC_READ, 7'd2, 7'd0, 8'sd0, 1'b1, -8'sd1, 1'b0},
    '{FUNC_READ, 7'd1, 7'd0, 8'sd0, 1'b1, 8'sd127, 1'b0},
    '{FUNC_RUN, 7'd64, 7'd64, 8'sd0, 1'b0, 8'sd0, 1'b0},
    '{FUNC_READ, 7'd1, 7'd1, 8'sd0, 1'b0, 8'sd0, 1'b0}
  };

  // Stimulus: reset, directed table, then phases of register settings.
  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_func       <= FUNC_WRITE;
    in_cell_x     <= '0;
    in_cell_y     <= '0;
    in_cell_value <= '0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    calm          = 1'b0;
    mismatches    = 0;
    area_w        = 128;
    area_h        = 128;
    occ_code      = 8'sd100;
    blk_code      = 8'sd99;
    flat_code_m   = 8'sd50;
    foreach (grid_model[i]) begin
      grid_model[i] = '0;
      cells_written[i] = 1'b0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_reg(REG_GRID_WIDTH, 8'd3);
    write_reg(REG_GRID_HEIGHT, 8'd3);
    foreach (directed_rows[i]) begin
      send_cell_item(directed_rows[i].func, directed_rows[i].x, directed_rows[i].y,
                     directed_rows[i].value, directed_rows[i].has_exp,
                     directed_rows[i].exp_value, directed_rows[i].exp_done);
    end

    // Extremes first: a full-width row with equal codes, a full-height
    // column where blocked minus one wraps, a zero-width area, and a width
    // beyond the store that the block clamps.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: program_grid(128, 1, 8'h80, 8'h80, 8'h7f);
        1: program_grid(1, 128, 8'h7f, 8'h80, 8'h80);
        2: program_grid(0, 5, 8'd100, 8'd99, 8'd50);
        3: program_grid(200, 2, 8'd100, 8'd100, 8'd20);
        default: program_grid($urandom_range(1, 10), $urandom_range(1, 10),
                              8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
      endcase
      calm = (phase == 5);
      fill_area();
      random_items(80);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // The receiver stalls at random, except during the calm phase.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 13);
    end
  end

  // Result checker: each beat taken is compared with the oldest expectation.
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("unexpected beat: read_value %0d done %0b", out_read_value, out_done_res);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value || out_done_res !== want.done) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("beat mismatch: read_value %0d (expected %0d), done %0b (expected %0b)",
                     out_read_value, want.read_value, out_done_res, want.done);
          end
        end
      end
    end
  end

  // Watchdog: too long with no beat on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ogsi_pkg.sv
hw/rtl/ogsi_ctrl.sv
hw/rtl/ogsi_dp.sv
hw/rtl/occupancy_grid_smooth_inflate_core.sv
hw/rtl/ogsi_checker.sv
tb/sv/testbench.sv
